### rtl/fr_pkg.sv
`default_nettype none

package fr_pkg;

    // Default word width of the numerator and denominator
    localparam int WORD_BITS_DEF = 32;

    // Smallest denominator that gets reduced
    localparam int MIN_REDUCE_DEN = 2;

    // Program counter of the control store
    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] t_pc;

    localparam t_pc PC_CHECK    = 4'd0;
    localparam t_pc PC_GCD_LOOP = 4'd1;
    localparam t_pc PC_GCD_OUT  = 4'd2;
    localparam t_pc PC_NUM_LOAD = 4'd3;
    localparam t_pc PC_NUM_DIV  = 4'd4;
    localparam t_pc PC_DEN_LOAD = 4'd5;
    localparam t_pc PC_DEN_DIV  = 4'd6;
    localparam t_pc PC_DEN_SAVE = 4'd7;
    localparam t_pc PC_FINISH   = 4'd8;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GCD_STEP,
        OP_GCD_DONE,
        OP_DIV_LOAD_NUM,
        OP_DIV_STEP,
        OP_DIV_LOAD_DEN,
        OP_DEN_SAVE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_SKIP,
        COND_GCD_RUN,
        COND_G_SMALL,
        COND_DIV_RUN
    } t_cond;

    typedef enum logic [1:0] {
        KIND_ZERO     = 2'd0,
        KIND_WHOLE    = 2'd1,
        KIND_FRACTION = 2'd2
    } t_kind;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // One control word: datapath operation plus a conditional jump
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control from sequencer to datapath
    typedef struct packed {
        t_op op;
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic skip;
        logic gcd_run;
        logic g_small;
        logic div_run;
        logic out_full;
    } t_stat;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        w = '{op: OP_NONE, cond: COND_NEVER, target: PC_CHECK};
        unique case (pc)
            PC_CHECK:    w = '{op: OP_NONE,         cond: COND_SKIP,    target: PC_FINISH};
            PC_GCD_LOOP: w = '{op: OP_GCD_STEP,     cond: COND_GCD_RUN, target: PC_GCD_LOOP};
            PC_GCD_OUT:  w = '{op: OP_GCD_DONE,     cond: COND_NEVER,   target: PC_CHECK};
            PC_NUM_LOAD: w = '{op: OP_DIV_LOAD_NUM, cond: COND_G_SMALL, target: PC_FINISH};
            PC_NUM_DIV:  w = '{op: OP_DIV_STEP,     cond: COND_DIV_RUN, target: PC_NUM_DIV};
            PC_DEN_LOAD: w = '{op: OP_DIV_LOAD_DEN, cond: COND_NEVER,   target: PC_CHECK};
            PC_DEN_DIV:  w = '{op: OP_DIV_STEP,     cond: COND_DIV_RUN, target: PC_DEN_DIV};
            PC_DEN_SAVE: w = '{op: OP_DEN_SAVE,     cond: COND_NEVER,   target: PC_CHECK};
            PC_FINISH:   w = '{op: OP_FINISH,       cond: COND_NEVER,   target: PC_CHECK};
            default:     w = '{op: OP_NONE,         cond: COND_NEVER,   target: PC_CHECK};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/fr_useq.sv
`default_nettype none

module fr_useq
    import fr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    t_seq_state r_state, n_state;
    t_pc        r_pc, n_pc;
    t_uword     uw;
    logic       jump;

    assign uw = ucode_rom(r_pc);

    always_comb begin
        case (uw.cond)
            COND_SKIP:    jump = i_stat.skip;
            COND_GCD_RUN: jump = i_stat.gcd_run;
            COND_G_SMALL: jump = i_stat.g_small;
            COND_DIV_RUN: jump = i_stat.div_run;
            default:      jump = 1'b0;
        endcase
    end

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_pc    = PC_CHECK;
                end
            end
            SEQ_RUN: begin
                if (uw.op == OP_FINISH) begin
                    // hold until the output register is free
                    if (!i_stat.out_full) begin
                        n_state = SEQ_IDLE;
                    end
                end else if (jump) begin
                    n_pc = uw.target;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl.op = OP_NONE;
        o_busy    = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                o_ctrl.op = OP_NONE;
                o_busy    = 1'b0;
            end
            SEQ_RUN: begin
                o_ctrl.op = uw.op;
                o_busy    = 1'b1;
            end
            default: begin
                o_ctrl.op = OP_NONE;
                o_busy    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= PC_CHECK;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

`default_nettype wire

### rtl/fr_datapath.sv
`default_nettype none

module fr_datapath
    import fr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [WORD_BITS-1:0] i_num,
    input  wire logic [WORD_BITS-1:0] i_den,
    input  wire t_ctrl                i_ctrl,
    output t_stat                     o_stat,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_num,
    output logic [WORD_BITS-1:0]      o_den,
    output t_kind                     o_kind
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_num, r_den, r_num_mag;
    logic                 r_neg, r_skip;
    logic [WORD_BITS-1:0] r_a, r_b, r_g;
    logic [CNT_W-1:0]     r_k, r_cnt;
    logic [WORD_BITS-1:0] r_rem, r_quo;
    logic                 r_o_valid;
    logic [WORD_BITS-1:0] r_o_num, r_o_den;
    t_kind                r_o_kind;

    logic [WORD_BITS-1:0] n_a, n_b;
    logic [CNT_W-1:0]     n_k;
    logic [WORD_BITS:0]   sh, diff;
    logic                 ge;
    logic                 in_neg;
    logic                 out_full;
    t_kind                kind;

    // One binary GCD step
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (r_a != '0 && r_b != '0) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = (r_a - r_b) >> 1;
            end else begin
                n_b = (r_b - r_a) >> 1;
            end
        end
    end

    // One restoring division step
    assign sh   = {r_rem, r_quo[WORD_BITS-1]};
    assign diff = sh - {1'b0, r_g};
    assign ge   = (sh >= {1'b0, r_g});

    assign in_neg   = i_num[WORD_BITS-1];
    assign out_full = r_o_valid && !i_ready;

    always_comb begin
        if (r_num == '0 || r_den == '0) begin
            kind = KIND_ZERO;
        end else if (r_den == WORD_BITS'(1)) begin
            kind = KIND_WHOLE;
        end else begin
            kind = KIND_FRACTION;
        end
    end

    assign o_stat.skip     = r_skip;
    assign o_stat.gcd_run  = (n_a != '0) && (n_b != '0);
    assign o_stat.g_small  = (r_g < WORD_BITS'(MIN_REDUCE_DEN));
    assign o_stat.div_run  = (r_cnt != DIV_LAST);
    assign o_stat.out_full = out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.op == OP_FINISH && !out_full) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num     <= i_num;
            r_den     <= i_den;
            r_neg     <= in_neg;
            r_num_mag <= in_neg ? WORD_BITS'(~i_num + 1'b1) : i_num;
            r_a       <= in_neg ? WORD_BITS'(~i_num + 1'b1) : i_num;
            r_b       <= i_den;
            r_k       <= '0;
            r_skip    <= i_den[WORD_BITS-1] || (i_den[WORD_BITS-1:1] == '0);
        end else begin
            case (i_ctrl.op)
                OP_GCD_STEP: begin
                    r_a <= n_a;
                    r_b <= n_b;
                    r_k <= n_k;
                end
                OP_GCD_DONE: begin
                    r_g <= WORD_BITS'((r_a | r_b) << r_k);
                end
                OP_DIV_LOAD_NUM: begin
                    r_rem <= '0;
                    r_quo <= r_num_mag;
                    r_cnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem <= ge ? diff[WORD_BITS-1:0] : sh[WORD_BITS-1:0];
                    r_quo <= {r_quo[WORD_BITS-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_DIV_LOAD_DEN: begin
                    r_num <= r_neg ? WORD_BITS'(~r_quo + 1'b1) : r_quo;
                    r_rem <= '0;
                    r_quo <= r_den;
                    r_cnt <= '0;
                end
                OP_DEN_SAVE: begin
                    r_den <= r_quo;
                end
                OP_FINISH: begin
                    if (!out_full) begin
                        r_o_num  <= r_num;
                        r_o_den  <= r_den;
                        r_o_kind <= kind;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_num   = r_o_num;
    assign o_den   = r_o_den;
    assign o_kind  = r_o_kind;

    // Partial remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DIV_STEP) |-> (r_rem < r_g))
        else $error("remainder not below divisor");

    // GCD loop leaves only when one operand is zero
    a_gcd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_GCD_DONE) |-> (r_a == '0 || r_b == '0))
        else $error("gcd left loop early");

    // Finishing with a free output register presents an item next cycle
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_FINISH && !out_full) |=> r_o_valid)
        else $error("finished item not presented");

endmodule

`default_nettype wire

### rtl/fraction_reduce.sv
// fraction_reduce: reduces a signed fraction by the GCD of its parts.
// A denominator below two passes straight through; otherwise a binary GCD loop finds g,
// and when g is two or more both parts are divided by it with a restoring divider.
// One item at a time: a new item is accepted only after the last one has moved into the
// output register, and the finish step holds while that register is still full.
// Reset: synchronous, active low; clears the sequencer and the output valid flag.
`default_nettype none

module fraction_reduce
    import fr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [WORD_BITS-1:0] i_numerator_in,
    input  wire logic [WORD_BITS-1:0] i_denominator_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [WORD_BITS-1:0]      o_numerator_out,
    output logic [WORD_BITS-1:0]      o_denominator_out,
    output logic [1:0]                o_kind
);

    // The sequencer walks a small control store:
    //   check for a denominator below two (pass through),
    //   binary GCD loop, form g, divide |num| by g, divide den by g,
    //   then hand the item to the output register.
    // A g below two also jumps straight to the finish step.

    t_ctrl ctrl;
    t_stat stat;
    logic  busy;
    logic  start;
    t_kind kind;

    // Accept a new item only while the sequencer is idle
    assign o_in_ready = !busy;
    assign start      = i_in_valid && !busy;

    fr_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // Datapath holds operands, GCD registers, the divider and the output register
    fr_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (start),
        .i_num   (i_numerator_in),
        .i_den   (i_denominator_in),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_num   (o_numerator_out),
        .o_den   (o_denominator_out),
        .o_kind  (kind)
    );

    assign o_kind = kind;

endmodule

`default_nettype wire

### sim/fraction_checker.sv
`timescale 1ns / 100ps

module fraction_checker
    import fr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [WORD_BITS-1:0] i_numerator_in,
    input  wire logic [WORD_BITS-1:0] i_denominator_in,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [WORD_BITS-1:0] i_numerator_out,
    input  wire logic [WORD_BITS-1:0] i_denominator_out,
    input  wire logic [1:0]           i_kind,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_reduced,
    output int                        o_passthrough
);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word num;
        t_word den;
        t_kind kind;
    } t_fraction;

    t_fraction expected_fractions[$];

    function automatic t_word gcd_of(input t_word a, input t_word b);
        t_word r;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_fraction reduce_fraction(input t_word num, input t_word den);
        t_fraction f;
        t_word     num_mag;
        t_word     g;
        logic      num_neg;
        f.num   = num;
        f.den   = den;
        num_neg = num[WORD_BITS-1];
        num_mag = num_neg ? -num : num;
        // Reduce only a non-negative denominator of two or more
        if (!den[WORD_BITS-1] && den >= t_word'(MIN_REDUCE_DEN)) begin
            g = gcd_of(num_mag, den);
            if (g >= t_word'(MIN_REDUCE_DEN)) begin
                f.num = num_neg ? -(num_mag / g) : (num_mag / g);
                f.den = den / g;
            end
        end
        if (f.num == '0 || f.den == '0) begin
            f.kind = KIND_ZERO;
        end else if (f.den == t_word'(1)) begin
            f.kind = KIND_WHOLE;
        end else begin
            f.kind = KIND_FRACTION;
        end
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_fractions.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d kind %0d with nothing pending",
                        $signed(i_numerator_out), $signed(i_denominator_out), i_kind));
                end else begin
                    want = expected_fractions.pop_front();
                    o_checked++;
                    if (i_numerator_out != want.num || i_denominator_out != want.den ||
                            i_kind != want.kind) begin
                        report_mismatch($sformatf("got %0d/%0d kind %0d, want %0d/%0d kind %0d",
                            $signed(i_numerator_out), $signed(i_denominator_out), i_kind,
                            $signed(want.num), $signed(want.den), want.kind));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = reduce_fraction(i_numerator_in, i_denominator_in);
                expected_fractions.push_back(want);
                if (want.den != i_denominator_in) begin
                    o_reduced++;
                end
                if ($signed(i_denominator_in) < MIN_REDUCE_DEN) begin
                    o_passthrough++;
                end
            end
            o_pending = expected_fractions.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import fr_pkg::*;

    localparam int WORD_BITS       = WORD_BITS_DEF;
    localparam int RANDOM_ITEMS    = 600;
    localparam int MAX_GAP         = 17;
    // Receiver holds off this long once, so the block fills and stalls its input
    localparam int HOLD_OFF_AT     = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    // Drain time after the last result, well over the worst reduce latency
    localparam int DRAIN_CYCLES    = 300;
    // Longest honest quiet stretch is the hold-off plus one reduce; allow many times that
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word MOST_POS = ~MOST_NEG;
    localparam t_word HALF_POS = MOST_POS >> 1;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_ready = 1'b0;
    t_word num_in    = '0;
    t_word den_in    = '0;

    logic       in_ready;
    logic       out_valid;
    t_word      num_out;
    t_word      den_out;
    logic [1:0] kind_out;

    int fail_count;
    int pending;
    int checked;
    int reduced;
    int passthrough;
    int items_sent  = 0;
    int idle_cycles = 0;

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fraction_reduce #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_numerator_in   (num_in),
        .i_denominator_in (den_in),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_numerator_out  (num_out),
        .o_denominator_out(den_out),
        .o_kind           (kind_out)
    );

    fraction_checker #(
        .WORD_BITS(WORD_BITS)
    ) checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_numerator_in   (num_in),
        .i_denominator_in (den_in),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_numerator_out  (num_out),
        .i_denominator_out(den_out),
        .i_kind           (kind_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_reduced        (reduced),
        .o_passthrough    (passthrough)
    );

    // Offer one item and hold it until the block takes it. Called at a rising edge.
    // Every 64 items, run the last 16 back to back with no gap.
    task automatic send_fraction(input t_word num, input t_word den);
        int gap;
        gap = ((items_sent % 64) >= 48) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        num_in   <= num;
        den_in   <= den;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    // Pick a fraction. Most carry a real common factor so the GCD loop and both
    // divisions run deep; the rest are raw bits, pass-through denominators,
    // corner numerators and tiny values.
    task automatic random_fraction(output t_word num, output t_word den);
        t_word g;
        t_word a;
        int    k;
        int    sel;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                num = $urandom();
                den = $urandom();
            end
            3, 4, 5, 6, 7, 8: begin
                g   = $urandom_range(2, $urandom_range(0, 1) ? 50 : 70000);
                a   = $urandom_range(0, MOST_POS / g);
                num = a * g;
                a   = $urandom_range(1, MOST_POS / g);
                den = a * g;
                if ($urandom_range(0, 1)) num = -num;
            end
            9, 10: begin
                // Power-of-two factor, up to the most negative numerator
                k   = $urandom_range(1, WORD_BITS - 2);
                a   = $urandom_range(0, MOST_POS >> k);
                num = a << k;
                a   = $urandom_range(1, MOST_POS >> k);
                den = a << k;
                if ($urandom_range(0, 1)) num = -num;
                if ($urandom_range(0, 7) == 0) num = MOST_NEG;
            end
            11: begin
                // Denominator divides numerator: reduces to a whole number
                den = $urandom_range(2, 100000);
                a   = $urandom_range(0, MOST_POS / den);
                num = a * den;
                if ($urandom_range(0, 1)) num = -num;
            end
            12: begin
                num = $urandom();
                sel = $urandom_range(0, 2);
                if (sel == 0)      den = '0;
                else if (sel == 1) den = t_word'(1);
                else               den = MOST_NEG | t_word'($urandom());
            end
            13: begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       num = '0;
                    1:       num = t_word'(1);
                    2:       num = '1;
                    3:       num = MOST_NEG;
                    default: num = MOST_POS;
                endcase
                den = $urandom_range(0, 1) ? t_word'($urandom()) : t_word'($urandom_range(2, 64));
            end
            default: begin
                num = t_word'(int'($urandom_range(0, 128)) - 64);
                den = t_word'(int'($urandom_range(0, 128)) - 64);
            end
        endcase
    endtask

    // Result side: random stall per item, stall-free stretches, and one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
            end else if ((taken % 64) >= 40) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results pending",
                idle_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        t_word num;
        t_word den;
        int    directed;
        int    i;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Zero numerators: reduce to 0/1 unless the denominator is below two
        send_fraction('0, t_word'(5));
        send_fraction('0, t_word'(1));
        send_fraction('0, -t_word'(7));
        send_fraction('0, '0);
        send_fraction('0, MOST_POS);
        // Denominator below two passes through: zero, one, negative
        send_fraction(t_word'(5), '0);
        send_fraction(t_word'(7), t_word'(1));
        send_fraction(t_word'(3), -t_word'(4));
        send_fraction(-t_word'(6), -t_word'(4));
        send_fraction(-t_word'(1), t_word'(1));
        send_fraction(t_word'(1073741824), MOST_NEG);
        // Ordinary reductions, sign kept on the numerator
        send_fraction(t_word'(12), t_word'(18));
        send_fraction(-t_word'(12), t_word'(18));
        send_fraction(t_word'(6), t_word'(3));
        // Coprime parts stay as they are
        send_fraction(t_word'(7), t_word'(13));
        send_fraction(t_word'(1), MOST_POS);
        send_fraction(MOST_NEG, MOST_POS);
        // Most negative numerator with an even denominator
        send_fraction(MOST_NEG, t_word'(2));
        send_fraction(MOST_NEG, t_word'(6));
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(MOST_NEG, HALF_POS + 1);
        // Widest values
        send_fraction(MOST_POS, MOST_POS);
        send_fraction(-MOST_POS, MOST_POS);
        send_fraction(MOST_POS - 1, t_word'(2));
        send_fraction('1, '1);
        directed = items_sent;

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            random_fraction(num, den);
            send_fraction(num, den);
        end
        in_valid <= 1'b0;

        // Wait out the last results, then give a stray one time to show up
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d fractions (%0d directed), compared %0d results.",
            items_sent, directed, checked);
        $display("%0d reduced by a common factor, %0d with a denominator below two.",
            reduced, passthrough);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/fr_pkg.sv
rtl/fr_useq.sv
rtl/fr_datapath.sv
rtl/fraction_reduce.sv
sim/fraction_checker.sv
sim/tb.sv
